[design/assert_macros.svh]
// Assertion macros shared by the row encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pbre_pkg.sv]
// Types and constants shared by the PackBits row encoder modules.
package pbre_pkg;

    localparam int MAX_ROW_BYTES = 4096;
    localparam int MAX_LITERAL   = 128;
    localparam int MAX_REPEAT    = 127;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 13;
    localparam int CNT_W       = 8;
    localparam int LIT_AW      = $clog2(MAX_LITERAL);
    localparam int RUN_W       = $clog2(MAX_REPEAT + 1);
    localparam int STORE_DEPTH = 2 * MAX_LITERAL;
    localparam int STORE_AW    = LIT_AW + 1;
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int PACK_W      = 64;
    localparam int FILL_W      = 3;

    localparam logic [LEN_W-1:0]  LEN_SAT     = '1;
    localparam logic [RUN_W-1:0]  RUN_MIN     = RUN_W'(3);
    localparam logic [RUN_W-1:0]  RUN_PAIR    = RUN_W'(2);
    localparam logic [RUN_W-1:0]  RUN_LIMIT   = RUN_W'(MAX_REPEAT);
    localparam logic [LIT_AW-1:0] LIT_LAST    = LIT_AW'(MAX_LITERAL - 1);
    localparam logic [CNT_W-1:0]  LIT_FULL    = CNT_W'(MAX_LITERAL);
    localparam logic [3:0]        PACK_BYTES  = 4'd8;
    localparam logic [8:0]        REPEAT_BASE = 9'd257;
    localparam logic [LEN_W:0]    LEN_MARGIN  = (LEN_W + 1)'(3);

    typedef enum logic [1:0] {
        OP_REPEAT,
        OP_FLUSH,
        OP_ROWEND
    } t_op;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              row_last;
    } t_in_beat;

    typedef struct packed {
        logic [PACK_W-1:0] packed_bytes;
        logic [3:0]        byte_count;
        logic              row_end;
        logic [LEN_W-1:0]  encoded_length;
        logic              too_long;
    } t_out_beat;

    // One queued job for the back end.
    typedef struct packed {
        t_op               op;
        logic [CNT_W-1:0]  cnt;
        logic [BYTE_W-1:0] val;
        logic              bank;
        logic [LEN_W-1:0]  len;
    } t_cmd;

    // Back end reports a literal bank fully read.
    typedef struct packed {
        logic done;
        logic bank;
    } t_flush_done;

endpackage

[design/pbre_ram.sv]
// Generic simple dual-port RAM with registered read.
module pbre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/pbre_cmd_fifo.sv]
// Short command queue between the classifying front end and the packing back end.
module pbre_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pbre_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pbre_pkg::t_cmd o_head
);
    import pbre_pkg::*;

    `include "assert_macros.svh"

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wptr;
    logic [CMD_PTR_W-1:0] r_rptr;
    logic [CMD_PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == (CMD_PTR_W + 1)'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    `PB_ASSERT_IMPL(a_pop_not_empty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")

endmodule

[design/pbre_front.sv]
// Front end: accepts row bytes, tracks runs and literals, fills the literal banks.
module pbre_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pbre_pkg::t_in_beat               i_in_data,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output pbre_pkg::t_cmd                   o_q_cmd,
    output logic                             o_st_we,
    output logic [pbre_pkg::STORE_AW-1:0]    o_st_waddr,
    output logic [pbre_pkg::BYTE_W-1:0]      o_st_wdata,
    input  pbre_pkg::t_flush_done            i_flush_done
);
    import pbre_pkg::*;

    `include "assert_macros.svh"

    localparam logic [2:0] FS_IDLE   = 3'd0;
    localparam logic [2:0] FS_ADD    = 3'd1;
    localparam logic [2:0] FS_LRES   = 3'd2;
    localparam logic [2:0] FS_LFLUSH = 3'd3;
    localparam logic [2:0] FS_LEND   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [BYTE_W-1:0] r_run_val, n_run_val;
    logic [RUN_W-1:0]  r_run_cnt, n_run_cnt;
    logic [LIT_AW-1:0] r_lit_cnt, n_lit_cnt;
    logic              r_bank, n_bank;
    logic [1:0]        r_busy, n_busy;
    logic [LEN_W-1:0]  r_row_cnt, n_row_cnt;
    logic              r_last, n_last;
    logic [BYTE_W-1:0] r_add_val, n_add_val;
    logic [1:0]        r_add_cnt, n_add_cnt;

    logic              accept;
    logic [LEN_W-1:0]  row_inc;
    logic              last_eff;
    logic [RUN_W-1:0]  run_inc;
    logic              do_add;
    logic [BYTE_W-1:0] add_val;

    function automatic t_cmd mk_cmd(t_op op, logic [CNT_W-1:0] cnt, logic [BYTE_W-1:0] val,
                                    logic bank, logic [LEN_W-1:0] len);
        t_cmd c;
        c.op   = op;
        c.cnt  = cnt;
        c.val  = val;
        c.bank = bank;
        c.len  = len;
        return c;
    endfunction

    assign o_in_stall = !((r_state == FS_IDLE) && !i_q_full && !r_busy[r_bank]);
    assign accept     = i_in_valid && !o_in_stall;
    assign row_inc    = (r_row_cnt == LEN_SAT) ? r_row_cnt : r_row_cnt + 1'b1;
    assign last_eff   = i_in_data.row_last || (32'(row_inc) == MAX_ROW_BYTES);
    assign run_inc    = r_run_cnt + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_run_val = r_run_val;
        n_run_cnt = r_run_cnt;
        n_lit_cnt = r_lit_cnt;
        n_bank    = r_bank;
        n_busy    = r_busy;
        n_row_cnt = r_row_cnt;
        n_last    = r_last;
        n_add_val = r_add_val;
        n_add_cnt = r_add_cnt;
        o_q_push  = 1'b0;
        o_q_cmd   = '0;
        do_add    = 1'b0;
        add_val   = r_add_val;

        if (i_flush_done.done) begin
            n_busy[i_flush_done.bank] = 1'b0;
        end

        case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    n_row_cnt = row_inc;
                    n_last    = last_eff;
                    if ((r_run_cnt != '0) && (i_in_data.data_byte == r_run_val)) begin
                        // Third equal byte closes the pending literal.
                        if ((run_inc == RUN_MIN) && (r_lit_cnt != '0)) begin
                            o_q_push       = 1'b1;
                            o_q_cmd        = mk_cmd(OP_FLUSH, CNT_W'(r_lit_cnt), '0, r_bank, '0);
                            n_bank         = !r_bank;
                            n_busy[r_bank] = 1'b1;
                            n_lit_cnt      = '0;
                        end
                        if (run_inc >= RUN_LIMIT) begin
                            o_q_push  = 1'b1;
                            o_q_cmd   = mk_cmd(OP_REPEAT, CNT_W'(run_inc), r_run_val, 1'b0, '0);
                            n_run_cnt = '0;
                        end else begin
                            n_run_cnt = run_inc;
                        end
                        n_state = last_eff ? FS_LRES : FS_IDLE;
                    end else begin
                        if (r_run_cnt >= RUN_MIN) begin
                            o_q_push = 1'b1;
                            o_q_cmd  = mk_cmd(OP_REPEAT, CNT_W'(r_run_cnt), r_run_val, 1'b0, '0);
                        end else if (r_run_cnt != '0) begin
                            do_add  = 1'b1;
                            add_val = r_run_val;
                        end
                        n_add_val = r_run_val;
                        n_add_cnt = (r_run_cnt == RUN_PAIR) ? 2'd1 : 2'd0;
                        n_run_val = i_in_data.data_byte;
                        n_run_cnt = RUN_W'(1);
                        if (r_run_cnt == RUN_PAIR) begin
                            n_state = FS_ADD;
                        end else begin
                            n_state = last_eff ? FS_LRES : FS_IDLE;
                        end
                    end
                end
            end
            FS_ADD: begin
                if (!i_q_full && !r_busy[r_bank]) begin
                    do_add    = 1'b1;
                    add_val   = r_add_val;
                    n_add_cnt = r_add_cnt - 2'd1;
                    if (r_add_cnt == 2'd1) begin
                        n_state = r_last ? FS_LRES : FS_IDLE;
                    end
                end
            end
            FS_LRES: begin
                if (r_run_cnt >= RUN_MIN) begin
                    if (!i_q_full) begin
                        o_q_push  = 1'b1;
                        o_q_cmd   = mk_cmd(OP_REPEAT, CNT_W'(r_run_cnt), r_run_val, 1'b0, '0);
                        n_run_cnt = '0;
                        n_state   = FS_LFLUSH;
                    end
                end else if (r_run_cnt != '0) begin
                    // Short leftover run joins the literal.
                    n_add_val = r_run_val;
                    n_add_cnt = r_run_cnt[1:0];
                    n_run_cnt = '0;
                    n_state   = FS_ADD;
                end else begin
                    n_state = FS_LFLUSH;
                end
            end
            FS_LFLUSH: begin
                if (r_lit_cnt != '0) begin
                    if (!i_q_full) begin
                        o_q_push       = 1'b1;
                        o_q_cmd        = mk_cmd(OP_FLUSH, CNT_W'(r_lit_cnt), '0, r_bank, '0);
                        n_bank         = !r_bank;
                        n_busy[r_bank] = 1'b1;
                        n_lit_cnt      = '0;
                        n_state        = FS_LEND;
                    end
                end else begin
                    n_state = FS_LEND;
                end
            end
            FS_LEND: begin
                if (!i_q_full) begin
                    o_q_push  = 1'b1;
                    o_q_cmd   = mk_cmd(OP_ROWEND, '0, '0, 1'b0, r_row_cnt);
                    n_row_cnt = '0;
                    n_run_val = '0;
                    n_run_cnt = '0;
                    n_lit_cnt = '0;
                    n_last    = 1'b0;
                    n_state   = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase

        // Append one literal byte; a full literal goes out at once.
        if (do_add) begin
            if (r_lit_cnt == LIT_LAST) begin
                o_q_push       = 1'b1;
                o_q_cmd        = mk_cmd(OP_FLUSH, LIT_FULL, '0, r_bank, '0);
                n_bank         = !r_bank;
                n_busy[r_bank] = 1'b1;
                n_lit_cnt      = '0;
            end else begin
                n_lit_cnt = r_lit_cnt + 1'b1;
            end
        end
    end

    assign o_st_we    = do_add;
    assign o_st_waddr = {r_bank, r_lit_cnt};
    assign o_st_wdata = add_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FS_IDLE;
            r_run_val <= '0;
            r_run_cnt <= '0;
            r_lit_cnt <= '0;
            r_bank    <= 1'b0;
            r_busy    <= '0;
            r_row_cnt <= '0;
            r_last    <= 1'b0;
            r_add_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_run_val <= n_run_val;
            r_run_cnt <= n_run_cnt;
            r_lit_cnt <= n_lit_cnt;
            r_bank    <= n_bank;
            r_busy    <= n_busy;
            r_row_cnt <= n_row_cnt;
            r_last    <= n_last;
            r_add_cnt <= n_add_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_add_val <= n_add_val;
    end

    `PB_ASSERT_IMPL(a_write_idle_bank, i_clk, i_rst_n, o_st_we, !r_busy[o_st_waddr[STORE_AW-1]], "literal write into a bank still draining")
    `PB_ASSERT_NEXT(a_flush_marks_busy, i_clk, i_rst_n, o_q_push && (o_q_cmd.op == OP_FLUSH), r_busy[$past(r_bank)], "flushed bank not marked busy")

endmodule

[design/pbre_back.sv]
// Back end: executes queued packets, packs code bytes eight to a beat.
module pbre_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  pbre_pkg::t_cmd                i_q_head,
    output logic                          o_q_pop,
    output logic [pbre_pkg::STORE_AW-1:0] o_st_raddr,
    input  logic [pbre_pkg::BYTE_W-1:0]   i_st_rdata,
    output pbre_pkg::t_flush_done         o_flush_done,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pbre_pkg::t_out_beat           o_out_data
);
    import pbre_pkg::*;

    `include "assert_macros.svh"

    logic [CNT_W-1:0]  r_step, n_step;
    logic [PACK_W-1:0] r_pack, n_pack;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [LEN_W-1:0]  r_out_len, n_out_len;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;

    logic              out_free;
    logic              go;
    logic              push;
    logic              rowend;
    logic              last_step;
    logic [BYTE_W-1:0] push_byte;
    logic [BYTE_W-1:0] hdr_rep;
    logic [CNT_W-1:0]  step_prev;
    logic [LIT_AW-1:0] rd_idx;
    logic [PACK_W-1:0] pk;
    logic              emit;
    t_out_beat         res;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign go        = i_q_valid && out_free;
    assign hdr_rep   = BYTE_W'(REPEAT_BASE - {1'b0, i_q_head.cnt});
    assign step_prev = r_step - 1'b1;

    always_comb begin
        push      = 1'b0;
        rowend    = 1'b0;
        last_step = 1'b1;
        push_byte = '0;
        case (i_q_head.op)
            OP_REPEAT: begin
                push      = 1'b1;
                push_byte = (r_step == '0) ? hdr_rep : i_q_head.val;
                last_step = (r_step == CNT_W'(1));
            end
            OP_FLUSH: begin
                push      = 1'b1;
                push_byte = (r_step == '0) ? i_q_head.cnt - 1'b1 : i_st_rdata;
                last_step = (r_step == i_q_head.cnt);
            end
            OP_ROWEND: begin
                rowend = 1'b1;
            end
            default: begin
                last_step = 1'b1;
            end
        endcase
    end

    // Read one entry ahead while advancing; hold the address while stalled.
    assign rd_idx     = go ? r_step[LIT_AW-1:0] : step_prev[LIT_AW-1:0];
    assign o_st_raddr = {i_q_head.bank, rd_idx};

    assign o_q_pop           = go && last_step;
    assign o_flush_done.done = go && last_step && (i_q_head.op == OP_FLUSH);
    assign o_flush_done.bank = i_q_head.bank;

    always_comb begin
        n_pack    = r_pack;
        n_fill    = r_fill;
        n_out_len = r_out_len;
        emit      = 1'b0;
        res       = '0;
        pk        = r_pack;
        n_step    = r_step;

        if (go) begin
            n_step = last_step ? '0 : r_step + 1'b1;
        end

        if (go && push) begin
            pk[{r_fill, 3'b000} +: BYTE_W] = push_byte;
            n_out_len = (r_out_len == LEN_SAT) ? r_out_len : r_out_len + 1'b1;
            if (r_fill == '1) begin
                emit             = 1'b1;
                res.packed_bytes = pk;
                res.byte_count   = PACK_BYTES;
                n_pack           = '0;
                n_fill           = '0;
            end else begin
                n_pack = pk;
                n_fill = r_fill + 1'b1;
            end
        end

        if (go && rowend) begin
            emit               = 1'b1;
            res.packed_bytes   = r_pack;
            res.byte_count     = {1'b0, r_fill};
            res.row_end        = 1'b1;
            res.encoded_length = r_out_len;
            res.too_long       = ({1'b0, r_out_len} + LEN_MARGIN) > {1'b0, i_q_head.len};
            n_pack             = '0;
            n_fill             = '0;
            n_out_len          = '0;
        end

        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (out_free) begin
            n_out_valid = emit;
            if (emit) begin
                n_out = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_pack      <= '0;
            r_fill      <= '0;
            r_out_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_pack      <= n_pack;
            r_fill      <= n_fill;
            r_out_len   <= n_out_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PB_ASSERT_IMPL(a_mid_row_full_word, i_clk, i_rst_n, r_out_valid && !r_out.row_end, (r_out.byte_count == PACK_BYTES) && (r_out.encoded_length == '0) && !r_out.too_long, "mid-row beat not a clean full word")
    `PB_ASSERT_NEXT(a_pop_clears_step, i_clk, i_rst_n, o_q_pop, r_step == '0, "step count not cleared after a packet")

endmodule

[design/packbits_row_encoder.sv]
// Top level of the PackBits row encoder.
//
// Bytes of a raster row enter one per beat, with row_last on the final byte, and
// leave as PackBits code packed eight bytes per output beat, first code byte in
// bits 7..0. Runs of three or more equal bytes become repeat packets (at most 127
// bytes each); all other bytes, including a leftover of one or two equal bytes,
// become literal packets of up to 128 bytes, and a literal is closed before any
// three equal bytes. Every row ends with one beat marked row_end that carries the
// remaining 0..7 code bytes, the saturating encoded length and the too_long flag
// (length above row length minus three). A row also ends at MAX_ROW_BYTES bytes.
// Rate: the front end takes one byte per cycle while not stalled; a byte breaking
// a run of exactly two adds a pass through FS_ADD, and row end passes FS_LRES,
// FS_LFLUSH and FS_LEND. The back end drains one code byte per cycle while its
// output is free (a literal emits a header and n bytes, a repeat a header and
// the value, a row end one beat), so long literals set the sustained rate. A
// four-entry command queue and a two-bank literal store sit between: input stalls
// while the front end is not idle, the queue is full or the bank it fills drains.
// The store needs no clearing: only entries written for the same literal are used.
module packbits_row_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pbre_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pbre_pkg::t_out_beat o_out_data
);
    import pbre_pkg::*;

    `include "assert_macros.svh"

    // Front end to queue.
    logic                q_push;
    t_cmd                q_cmd;
    logic                q_full;
    // Queue to back end.
    logic                q_valid;
    logic                q_pop;
    t_cmd                q_head;
    // Literal store ports.
    logic                st_we;
    logic [STORE_AW-1:0] st_waddr;
    logic [BYTE_W-1:0]   st_wdata;
    logic [STORE_AW-1:0] st_raddr;
    logic [BYTE_W-1:0]   st_rdata;
    // Back end frees a literal bank.
    t_flush_done         flush_done;

    // Classify bytes, fill the literal banks, queue packets.
    pbre_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_cmd),
        .o_st_we      (st_we),
        .o_st_waddr   (st_waddr),
        .o_st_wdata   (st_wdata),
        .i_flush_done (flush_done)
    );

    // Two banks of literal bytes, one filling while the other drains.
    pbre_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_lit_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Decouple classification from packing.
    pbre_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Emit packet bytes and pack them into output beats.
    pbre_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .o_st_raddr   (st_raddr),
        .i_st_rdata   (st_rdata),
        .o_flush_done (flush_done),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

    `PB_ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, q_push, !q_full, "command pushed into a full queue")

endmodule
